[src/dra_pkg.sv]
// Shared types and constants of the interval-list identifier allocator.
// Used by dra_cell, dlci_range_allocator_top and dra_chk; no dependencies.
package dra_pkg;

  localparam int DEF_MAX_INTERVALS = 16;
  localparam int DEF_ID_BITS       = 10;
  localparam int OP_BITS           = 3;
  localparam int ST_BITS           = 3;
  localparam int CFG_IDX_BITS      = 2;

  // Fallback range loaded when the configured bounds are inverted
  localparam int unsigned FALLBACK_LO = 512;
  localparam int unsigned FALLBACK_HI = 991;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ID  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_ID   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEF_DIR   = 2'd2;

  typedef enum logic [OP_BITS-1:0] {
    OP_ALLOC_DEF  = 3'd0,
    OP_ALLOC_ASC  = 3'd1,
    OP_ALLOC_DESC = 3'd2,
    OP_FREE       = 3'd3,
    OP_REINIT     = 3'd4
  } opcode_e;

  typedef enum logic [ST_BITS-1:0] {
    STAT_GRANTED   = 3'd0,
    STAT_EXHAUSTED = 3'd1,
    STAT_FREED     = 3'd2,
    STAT_RANGE     = 3'd3,
    STAT_DUP       = 3'd4,
    STAT_FULL      = 3'd5,
    STAT_REINIT    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } fsm_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [3:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ASC_TRIM,
    CELL_SHIFT_L,
    CELL_DESC,
    CELL_INSERT,
    CELL_GROW_END,
    CELL_GROW_START,
    CELL_JOIN
  } cell_op_e;

  // Per-cell view of the pending identifier, registered inside the cell
  typedef struct packed {
    logic lt;      // valid interval starting below the identifier
    logic hit;     // identifier already inside this interval
    logic pa;      // interval ends just below the identifier
    logic sa;      // interval starts just above the identifier
    logic single;  // interval holds one identifier
    logic last;    // highest valid interval
  } dra_flags_t;

endpackage

[src/dra_cell.sv]
// One interval slot of the allocator chain: start, end, valid and its flags.
// Depends on dra_pkg; talks only to its left and right neighbours.
module dra_cell import dra_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS,
  parameter bit FIRST   = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_op_e           op_i,
  input  logic [ID_BITS-1:0] id_i,
  input  logic [ID_BITS-1:0] lo_i,
  input  logic [ID_BITS-1:0] hi_i,
  input  logic [ID_BITS-1:0] prev_start_i,
  input  logic [ID_BITS-1:0] prev_end_i,
  input  logic               prev_valid_i,
  input  logic               prev_lt_i,
  input  logic [ID_BITS-1:0] next_start_i,
  input  logic [ID_BITS-1:0] next_end_i,
  input  logic               next_valid_i,
  output logic [ID_BITS-1:0] start_o,
  output logic [ID_BITS-1:0] end_o,
  output logic               valid_o,
  output dra_flags_t         flags_o,
  output logic [ID_BITS-1:0] last_end_o
);

  localparam logic [ID_BITS-1:0] FB_LO = ID_BITS'(FALLBACK_LO);
  localparam logic [ID_BITS-1:0] FB_HI = ID_BITS'(FALLBACK_HI);

  logic [ID_BITS-1:0] start_q, start_d, end_q, end_d, last_end_q, last_end_d;
  logic               valid_q, valid_d;
  dra_flags_t         flags_q, flags_d;
  logic [ID_BITS:0]   end_inc, id_inc;

  assign end_inc = {1'b0, end_q} + 1'b1;
  assign id_inc  = {1'b0, id_i} + 1'b1;

  always_comb begin
    flags_d.lt     = valid_q && (start_q < id_i);
    flags_d.hit    = valid_q && (start_q <= id_i) && (id_i <= end_q);
    flags_d.pa     = valid_q && (start_q < id_i) && (end_inc == {1'b0, id_i});
    flags_d.sa     = valid_q && !(start_q < id_i) && ({1'b0, start_q} == id_inc);
    flags_d.single = (start_q == end_q);
    flags_d.last   = valid_q && !next_valid_i;
    last_end_d     = flags_d.last ? end_q : '0;
  end

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    valid_d = valid_q;
    case (op_i)
      CELL_LOAD: begin
        valid_d = FIRST;
        start_d = lo_i;
        end_d   = hi_i;
      end
      CELL_ASC_TRIM: begin
        if (FIRST) start_d = start_q + 1'b1;
      end
      CELL_SHIFT_L: begin
        start_d = next_start_i;
        end_d   = next_end_i;
        valid_d = next_valid_i;
      end
      CELL_DESC: begin
        if (flags_q.last) begin
          if (flags_q.single) valid_d = 1'b0;
          else end_d = end_q - 1'b1;
        end
      end
      CELL_INSERT: begin
        if (!flags_q.lt) begin
          if (prev_lt_i) begin
            start_d = id_i;
            end_d   = id_i;
            valid_d = 1'b1;
          end else begin
            start_d = prev_start_i;
            end_d   = prev_end_i;
            valid_d = prev_valid_i;
          end
        end
      end
      CELL_GROW_END: begin
        if (flags_q.pa) end_d = id_i;
      end
      CELL_GROW_START: begin
        if (flags_q.sa) start_d = id_i;
      end
      CELL_JOIN: begin
        if (flags_q.pa) begin
          end_d = next_end_i;
        end else if (!flags_q.lt) begin
          start_d = next_start_i;
          end_d   = next_end_i;
          valid_d = next_valid_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= FIRST;
      start_q <= FB_LO;
      end_q   <= FB_HI;
    end else begin
      valid_q <= valid_d;
      start_q <= start_d;
      end_q   <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q    <= flags_d;
    last_end_q <= last_end_d;
  end

  assign start_o    = start_q;
  assign end_o      = end_q;
  assign valid_o    = valid_q;
  assign flags_o    = flags_q;
  assign last_end_o = last_end_q;

endmodule

[src/dlci_range_allocator_top.sv]
// Top level of the interval-list identifier allocator: handshake, control
// sequencer, configuration registers and the chain of dra_cell slots. Uses dra_pkg.
//
// Usage:
//   Input channel s_axis_*: one item per request (opcode, release_id).
//   Output channel m_axis_*: exactly one item per request (granted_id, status).
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 first_id, 1 last_id, 2 default_direction); write only while idle.
//   first_id and last_id take effect at a reinitialise request.
// Timing:
//   An item passes three steps: accept, evaluate (each cell compares its
//   interval with the identifier and registers its flags), apply (the chain
//   shifts or edits by one place and the result is loaded into the output
//   register). A new item is accepted only once the previous one is applied.
//   The steps are the same whatever the list length.
// Reset: the chain holds one interval 512..991, the rest of the slots empty.
// Stall: a result waits in the output register; the next item is accepted
//   and evaluated meanwhile, and apply waits until the register is free.
module dlci_range_allocator_top import dra_pkg::*; #(
  parameter int  MAX_INTERVALS = DEF_MAX_INTERVALS,
  parameter int  ID_BITS       = DEF_ID_BITS,
  localparam int S_W           = ((OP_BITS + ID_BITS + 7) / 8) * 8,
  localparam int M_W           = ((ID_BITS + ST_BITS + 7) / 8) * 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [S_W-1:0]          s_axis_tdata_i,   // opcode, release_id, zero pad
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [M_W-1:0]          m_axis_tdata_o,   // granted_id, status, zero pad
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [ID_BITS-1:0]      cfg_data_i
);

  localparam logic [ID_BITS-1:0] FB_LO = ID_BITS'(FALLBACK_LO);
  localparam logic [ID_BITS-1:0] FB_HI = ID_BITS'(FALLBACK_HI);

  // Control and configuration state
  fsm_e                 state_q, state_d;
  logic [OP_BITS-1:0]   op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [ID_BITS-1:0]   cfg_first_q, cfg_last_q;
  logic                 cfg_dir_q;
  logic [ID_BITS-1:0]   range_lo_q, range_hi_q;
  logic                 out_valid_q;
  logic [ID_BITS-1:0]   out_id_q;
  logic [ST_BITS-1:0]   out_status_q;

  logic                 in_fire, apply_fire;
  cell_op_e             cell_op, dec_op;
  logic [ID_BITS-1:0]   dec_id;
  status_e              dec_status;
  logic                 dec_load, use_desc;
  logic [ID_BITS-1:0]   load_lo, load_hi;

  // Chain wiring
  logic [ID_BITS-1:0] cell_start [MAX_INTERVALS];
  logic [ID_BITS-1:0] cell_end   [MAX_INTERVALS];
  logic [ID_BITS-1:0] cell_lend  [MAX_INTERVALS];
  logic               cell_valid [MAX_INTERVALS];
  dra_flags_t         cell_flags [MAX_INTERVALS];

  logic               any_hit, any_pa, any_sa;
  logic [ID_BITS-1:0] desc_id;

  // Input handshake and sequencer
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_fire) state_d = S_EVAL;
      S_EVAL:  state_d = S_APPLY;
      S_APPLY: if (apply_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    apply_fire      = (state_q == S_APPLY) && (!out_valid_q || m_axis_tready_i);
    cell_op         = apply_fire ? dec_op : CELL_HOLD;
  end

  // Collect cell flags: a plain OR over the row, at most one cell sets pa/sa/last
  always_comb begin
    any_hit = 1'b0;
    any_pa  = 1'b0;
    any_sa  = 1'b0;
    desc_id = '0;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      any_hit = any_hit | cell_flags[i].hit;
      any_pa  = any_pa  | cell_flags[i].pa;
      any_sa  = any_sa  | cell_flags[i].sa;
      desc_id = desc_id | cell_lend[i];
    end
  end

  // Fall back to the default range when the bounds are inverted
  always_comb begin
    if (cfg_first_q > cfg_last_q) begin
      load_lo = FB_LO;
      load_hi = FB_HI;
    end else begin
      load_lo = cfg_first_q;
      load_hi = cfg_last_q;
    end
  end

  // Decide the result and the chain command for the pending item
  always_comb begin
    dec_op     = CELL_HOLD;
    dec_id     = '0;
    dec_status = STAT_RANGE;
    dec_load   = 1'b0;
    use_desc   = (op_q == OP_ALLOC_DESC) || ((op_q == OP_ALLOC_DEF) && cfg_dir_q);
    case (op_q)
      OP_ALLOC_DEF, OP_ALLOC_ASC, OP_ALLOC_DESC: begin
        if (!cell_valid[0]) begin
          dec_status = STAT_EXHAUSTED;
        end else if (use_desc) begin
          dec_status = STAT_GRANTED;
          dec_id     = desc_id;
          dec_op     = CELL_DESC;
        end else begin
          dec_status = STAT_GRANTED;
          dec_id     = cell_start[0];
          dec_op     = cell_flags[0].single ? CELL_SHIFT_L : CELL_ASC_TRIM;
        end
      end
      OP_FREE: begin
        if ((id_q < range_lo_q) || (id_q > range_hi_q)) begin
          dec_status = STAT_RANGE;
        end else if (any_hit) begin
          dec_status = STAT_DUP;
        end else if (cell_valid[MAX_INTERVALS-1]) begin
          dec_status = STAT_FULL;
        end else begin
          dec_status = STAT_FREED;
          if (any_pa && any_sa) dec_op = CELL_JOIN;
          else if (any_pa)      dec_op = CELL_GROW_END;
          else if (any_sa)      dec_op = CELL_GROW_START;
          else                  dec_op = CELL_INSERT;
        end
      end
      OP_REINIT: begin
        dec_status = STAT_REINIT;
        dec_op     = CELL_LOAD;
        dec_load   = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer, configuration and latched range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_first_q <= FB_LO;
      cfg_last_q  <= FB_HI;
      cfg_dir_q   <= 1'b0;
      range_lo_q  <= FB_LO;
      range_hi_q  <= FB_HI;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FIRST_ID) cfg_first_q <= cfg_data_i;
        if (cfg_index_i == CFG_LAST_ID)  cfg_last_q  <= cfg_data_i;
        if (cfg_index_i == CFG_DEF_DIR)  cfg_dir_q   <= cfg_data_i[0];
      end
      if (apply_fire && dec_load) begin
        range_lo_q <= load_lo;
        range_hi_q <= load_hi;
      end
      if (apply_fire)                out_valid_q <= 1'b1;
      else if (m_axis_tready_i)      out_valid_q <= 1'b0;
    end
  end

  // Item payload and result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= s_axis_tdata_i[OP_BITS-1:0];
      id_q <= s_axis_tdata_i[OP_BITS +: ID_BITS];
    end
    if (apply_fire) begin
      out_id_q     <= dec_id;
      out_status_q <= dec_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(M_W - ID_BITS - ST_BITS){1'b0}}, out_status_q, out_id_q};

  // Row of interval cells; each one sees only its two neighbours
  for (genvar g = 0; g < MAX_INTERVALS; g++) begin : g_cell
    logic [ID_BITS-1:0] p_start, p_end, n_start, n_end;
    logic               p_valid, p_lt, n_valid;

    if (g == 0) begin : g_left_edge
      assign p_start = '0;
      assign p_end   = '0;
      assign p_valid = 1'b0;
      assign p_lt    = 1'b1;
    end else begin : g_left
      assign p_start = cell_start[g-1];
      assign p_end   = cell_end[g-1];
      assign p_valid = cell_valid[g-1];
      assign p_lt    = cell_flags[g-1].lt;
    end

    if (g == MAX_INTERVALS - 1) begin : g_right_edge
      assign n_start = '0;
      assign n_end   = '0;
      assign n_valid = 1'b0;
    end else begin : g_right
      assign n_start = cell_start[g+1];
      assign n_end   = cell_end[g+1];
      assign n_valid = cell_valid[g+1];
    end

    dra_cell #(
      .ID_BITS (ID_BITS),
      .FIRST   (g == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .id_i         (id_q),
      .lo_i         (load_lo),
      .hi_i         (load_hi),
      .prev_start_i (p_start),
      .prev_end_i   (p_end),
      .prev_valid_i (p_valid),
      .prev_lt_i    (p_lt),
      .next_start_i (n_start),
      .next_end_i   (n_end),
      .next_valid_i (n_valid),
      .start_o      (cell_start[g]),
      .end_o        (cell_end[g]),
      .valid_o      (cell_valid[g]),
      .flags_o      (cell_flags[g]),
      .last_end_o   (cell_lend[g])
    );
  end

endmodule

[src/dra_chk.sv]
// Port-level checker for dlci_range_allocator_top, attached by bind below.
// Depends on dra_pkg.
module dra_chk import dra_pkg::*; #(
  parameter int  ID_BITS = DEF_ID_BITS,
  localparam int S_W     = ((OP_BITS + ID_BITS + 7) / 8) * 8,
  localparam int M_W     = ((ID_BITS + ST_BITS + 7) / 8) * 8
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           s_axis_tvalid_i,
  input logic           s_axis_tready_o,
  input logic [S_W-1:0] s_axis_tdata_i,
  input logic           m_axis_tvalid_o,
  input logic           m_axis_tready_i,
  input logic [M_W-1:0] m_axis_tdata_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == s_axis_tdata_i);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // One item in flight: no accept straight after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready_o)
    else $error("item accepted while busy");

  // A result needs the evaluate step before it shows
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result too early");

  // Only a grant carries an identifier
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[ID_BITS +: ST_BITS] != STAT_GRANTED)
      |-> (m_axis_tdata_o[ID_BITS-1:0] == '0))
    else $error("identifier on a non-grant result");

endmodule

bind dlci_range_allocator_top dra_chk #(.ID_BITS(ID_BITS)) u_dra_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
